FILE: hw/rtl/afsd_pkg.sv
// ----------------------------------------------------------------------------
// afsd_pkg
// Types and constants shared by the flag string decoder.
// ----------------------------------------------------------------------------
package afsd_pkg;

  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ACC_W       = 17;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd65510;
  localparam logic [ACC_W-1:0]   ACC_CAP     = 17'h10000;
  localparam logic [15:0]        REPL_CHAR   = 16'hFFFD;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MODE  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_PAIR   = 2'd1,
    MODE_DEC    = 2'd2,
    MODE_UTF8   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_ZERO  = 3'd2,
    ST_ODD   = 3'd3,
    ST_UTF   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    NP_LEAD     = 3'd0,
    NP_POS      = 3'd1,
    NP_NEG      = 3'd2,
    NP_STOP_POS = 3'd3,
    NP_STOP_NEG = 3'd4
  } phase_t;

  // how the back end finishes an item
  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,  // id space check only
    KIND_PAIR   = 2'd1,  // id space and limit checks
    KIND_NUMBER = 2'd2,  // sign, id space, limit and zero checks
    KIND_ODD    = 2'd3   // lone trailing byte
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ACC_W-1:0] raw;
    logic             neg;
    status_t          status;
    logic             done;
  } item_t;

endpackage

FILE: hw/rtl/afsd_in_if.sv
// ----------------------------------------------------------------------------
// afsd_in_if
// Byte channel: one byte of the flag string per beat.
// ----------------------------------------------------------------------------
interface afsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

FILE: hw/rtl/afsd_out_if.sv
// ----------------------------------------------------------------------------
// afsd_out_if
// Result channel: one decoded flag entry per beat.
// ----------------------------------------------------------------------------
interface afsd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] flag_id;
  logic        flag_valid;
  logic [2:0]  status;
  logic        string_done;

  modport source (output valid, output flag_id, output flag_valid, output status,
                  output string_done, input ready);
  modport sink   (input valid, input flag_id, input flag_valid, input status,
                  input string_done, output ready);
endinterface

FILE: hw/rtl/afsd_front.sv
// ----------------------------------------------------------------------------
// afsd_front
// Per-string parser: updates decode state per byte, emits raw items.
// ----------------------------------------------------------------------------
module afsd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  afsd_pkg::mode_t       mode,
  input  logic                  accept,
  input  logic [7:0]            byte_in,
  input  logic                  last,
  output logic                  push,
  output afsd_pkg::item_t       item
);

  logic [7:0]                     pend, pend_next;
  logic                           have, have_next;
  logic [afsd_pkg::ACC_W-1:0]     acc, acc_next;
  afsd_pkg::phase_t               phase, phase_next;
  logic [15:0]                    code, code_next;
  logic [1:0]                     left, left_next;

  logic                           is_digit;
  logic                           is_blank;
  logic [3:0]                     dval;
  logic [20:0]                    acc_x10;
  logic [afsd_pkg::ACC_W-1:0]     acc_step;
  logic [15:0]                    code_shift;

  assign is_digit   = (byte_in >= afsd_pkg::CH_ZERO) && (byte_in <= afsd_pkg::CH_NINE);
  assign is_blank   = (byte_in == afsd_pkg::CH_SPACE) ||
                      ((byte_in >= afsd_pkg::CH_TAB) && (byte_in <= afsd_pkg::CH_CR));
  assign dval       = 4'(byte_in - afsd_pkg::CH_ZERO);
  assign acc_x10    = 21'({acc, 3'b000}) + 21'({acc, 1'b0}) + 21'(dval);
  assign acc_step   = (acc_x10 > 21'(afsd_pkg::ACC_CAP)) ? afsd_pkg::ACC_CAP
                                                         : acc_x10[afsd_pkg::ACC_W-1:0];
  assign code_shift = {code[9:0], byte_in[5:0]};

  always_comb begin
    pend_next  = pend;
    have_next  = have;
    acc_next   = acc;
    phase_next = phase;
    code_next  = code;
    left_next  = left;
    push       = 1'b0;
    item       = '0;
    item.done  = last;

    if (accept) begin
      unique case (mode)
        afsd_pkg::MODE_PAIR: begin
          if (have) begin
            push      = 1'b1;
            item.kind = afsd_pkg::KIND_PAIR;
            item.raw  = afsd_pkg::ACC_W'({pend, byte_in});
            have_next = 1'b0;
          end else if (last) begin
            push      = 1'b1;
            item.kind = afsd_pkg::KIND_ODD;
          end else begin
            pend_next = byte_in;
            have_next = 1'b1;
          end
        end

        afsd_pkg::MODE_DEC: begin
          if (byte_in == afsd_pkg::CH_COMMA) begin
            push       = 1'b1;
            item.kind  = afsd_pkg::KIND_NUMBER;
            item.raw   = acc;
            item.neg   = (phase == afsd_pkg::NP_NEG) || (phase == afsd_pkg::NP_STOP_NEG);
            acc_next   = '0;
            phase_next = afsd_pkg::NP_LEAD;
          end else begin
            unique case (phase)
              afsd_pkg::NP_LEAD: begin
                priority if (is_blank) begin
                  phase_next = afsd_pkg::NP_LEAD;
                end else if (byte_in == afsd_pkg::CH_PLUS) begin
                  phase_next = afsd_pkg::NP_POS;
                end else if (byte_in == afsd_pkg::CH_MINUS) begin
                  phase_next = afsd_pkg::NP_NEG;
                end else if (is_digit) begin
                  phase_next = afsd_pkg::NP_POS;
                  acc_next   = afsd_pkg::ACC_W'(dval);
                end else begin
                  phase_next = afsd_pkg::NP_STOP_POS;
                end
              end
              afsd_pkg::NP_POS: begin
                if (is_digit) acc_next = acc_step;
                else          phase_next = afsd_pkg::NP_STOP_POS;
              end
              afsd_pkg::NP_NEG: begin
                if (is_digit) acc_next = acc_step;
                else          phase_next = afsd_pkg::NP_STOP_NEG;
              end
              default: begin
                phase_next = phase;
              end
            endcase
            if (last) begin
              push      = 1'b1;
              item.kind = afsd_pkg::KIND_NUMBER;
              item.raw  = acc_next;
              item.neg  = (phase_next == afsd_pkg::NP_NEG) ||
                          (phase_next == afsd_pkg::NP_STOP_NEG);
            end
          end
        end

        afsd_pkg::MODE_UTF8: begin
          item.kind = afsd_pkg::KIND_PLAIN;
          if (left != 2'd0) begin
            if (byte_in[7:6] == 2'b10) begin
              code_next = code_shift;
              left_next = left - 2'd1;
              if (left == 2'd1) begin
                push        = 1'b1;
                item.raw    = afsd_pkg::ACC_W'(code_shift);
                item.status = afsd_pkg::ST_OK;
                code_next   = '0;
              end else if (last) begin
                push        = 1'b1;
                item.raw    = afsd_pkg::ACC_W'(afsd_pkg::REPL_CHAR);
                item.status = afsd_pkg::ST_UTF;
              end
            end else begin
              left_next   = '0;
              code_next   = '0;
              push        = 1'b1;
              item.raw    = afsd_pkg::ACC_W'(afsd_pkg::REPL_CHAR);
              item.status = afsd_pkg::ST_UTF;
            end
          end else if (!byte_in[7]) begin
            push        = 1'b1;
            item.raw    = afsd_pkg::ACC_W'(byte_in);
            item.status = afsd_pkg::ST_OK;
          end else if ((byte_in[7:6] == 2'b10) || (byte_in[7:4] == 4'hF) || last) begin
            // stray continuation, 4-byte or invalid lead, or lead cut off
            push        = 1'b1;
            item.raw    = afsd_pkg::ACC_W'(afsd_pkg::REPL_CHAR);
            item.status = afsd_pkg::ST_UTF;
          end else if (!byte_in[5]) begin
            code_next = 16'(byte_in[4:0]);
            left_next = 2'd1;
          end else begin
            code_next = 16'(byte_in[3:0]);
            left_next = 2'd2;
          end
        end

        default: begin
          push        = 1'b1;
          item.kind   = afsd_pkg::KIND_PLAIN;
          item.raw    = afsd_pkg::ACC_W'(byte_in);
          item.status = afsd_pkg::ST_OK;
        end
      endcase

      if (last) begin
        pend_next  = '0;
        have_next  = 1'b0;
        acc_next   = '0;
        phase_next = afsd_pkg::NP_LEAD;
        code_next  = '0;
        left_next  = '0;
      end
    end

    if (clear) begin
      pend_next  = '0;
      have_next  = 1'b0;
      acc_next   = '0;
      phase_next = afsd_pkg::NP_LEAD;
      code_next  = '0;
      left_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      have  <= 1'b0;
      acc   <= '0;
      phase <= afsd_pkg::NP_LEAD;
      code  <= '0;
      left  <= '0;
    end else begin
      pend  <= pend_next;
      have  <= have_next;
      acc   <= acc_next;
      phase <= phase_next;
      code  <= code_next;
      left  <= left_next;
    end
  end

endmodule

FILE: hw/rtl/afsd_queue.sv
// ----------------------------------------------------------------------------
// afsd_queue
// Small FIFO of raw items between parser and finisher.
// ----------------------------------------------------------------------------
module afsd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  afsd_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output afsd_pkg::item_t head
);

  localparam int unsigned PTR_W = (afsd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(afsd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(afsd_pkg::QUEUE_DEPTH + 1);

  afsd_pkg::item_t  mem [afsd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(afsd_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(afsd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (!push && pop) count <= count - CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/afsd_back.sv
// ----------------------------------------------------------------------------
// afsd_back
// Range and zero checks, then the registered result beat.
// ----------------------------------------------------------------------------
module afsd_back #(
  parameter int unsigned FLAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [afsd_pkg::LIMIT_W-1:0]  limit,
  input  logic                          q_valid,
  input  afsd_pkg::item_t               q_item,
  output logic                          pop,
  afsd_out_if.source                    flags
);

  localparam logic [afsd_pkg::ACC_W-1:0] ID_SPACE = afsd_pkg::ACC_W'(1) << FLAG_BITS;

  logic                 over_space, over_limit;
  logic [15:0]          id_c;
  logic                 fv_c;
  afsd_pkg::status_t    st_c;

  logic                 ovalid;
  logic [15:0]          oid;
  logic                 ofv;
  afsd_pkg::status_t    ost;
  logic                 odone;

  assign over_space = q_item.raw >= ID_SPACE;
  assign over_limit = q_item.raw >= afsd_pkg::ACC_W'(limit);
  assign pop        = q_valid && (!ovalid || flags.ready);

  always_comb begin
    id_c = q_item.raw[15:0];
    fv_c = 1'b1;
    st_c = q_item.status;
    unique case (q_item.kind)
      afsd_pkg::KIND_PLAIN: begin
        if (over_space) begin
          id_c = '0;
          st_c = afsd_pkg::ST_RANGE;
        end
      end
      afsd_pkg::KIND_PAIR: begin
        if (over_space || over_limit) begin
          id_c = '0;
          st_c = afsd_pkg::ST_RANGE;
        end else begin
          st_c = afsd_pkg::ST_OK;
        end
      end
      afsd_pkg::KIND_NUMBER: begin
        priority if ((q_item.neg && (q_item.raw != '0)) || over_space || over_limit) begin
          id_c = '0;
          st_c = afsd_pkg::ST_RANGE;
        end else if (q_item.raw == '0) begin
          st_c = afsd_pkg::ST_ZERO;
        end else begin
          st_c = afsd_pkg::ST_OK;
        end
      end
      default: begin
        id_c = '0;
        fv_c = 1'b0;
        st_c = afsd_pkg::ST_ODD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (pop) begin
      ovalid <= 1'b1;
    end else if (flags.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      oid   <= id_c;
      ofv   <= fv_c;
      ost   <= st_c;
      odone <= q_item.done;
    end
  end

  assign flags.valid       = ovalid;
  assign flags.flag_id     = oid;
  assign flags.flag_valid  = ofv;
  assign flags.status      = 3'(ost);
  assign flags.string_done = odone;

endmodule

FILE: hw/rtl/affix_flag_string_decoder.sv
// The accepting edge pushes the item into the queue; the result register then loads
//   it from the queue head when that register is empty or its beat is being taken.
// Throughput: one byte per cycle; bytes.ready drops only when the two-entry item queue
//   is full, which a steady stream reaches when the result side stalls.
// Reset (rst, synchronous): mode 0, limit 65510, parse state cleared, queue and
//   output register empty.
// ----------------------------------------------------------------------------
// affix_flag_string_decoder
// Turns a flag string, one byte per beat, into 16-bit flag ids.
// ----------------------------------------------------------------------------
module affix_flag_string_decoder #(
  parameter int unsigned FLAG_BITS = 16   // id space is 2^FLAG_BITS, 8..16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [0:0]                     cfg_index,
  input  logic [afsd_pkg::LIMIT_W-1:0]   cfg_wr_data,
  afsd_in_if.sink                        bytes,
  afsd_out_if.source                     flags
);

  // Configuration registers. Any write also restarts the string parse.
  afsd_pkg::mode_t                 mode;
  logic [afsd_pkg::LIMIT_W-1:0]    limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= afsd_pkg::MODE_SINGLE;
      limit <= afsd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (afsd_pkg::cfg_index_t'(cfg_index))
        afsd_pkg::CFG_MODE:  mode  <= afsd_pkg::mode_t'(cfg_wr_data[1:0]);
        afsd_pkg::CFG_LIMIT: limit <= cfg_wr_data;
        default:             mode  <= mode;
      endcase
    end
  end

  // Front end: byte accepted whenever the queue has room.
  logic            q_full, q_not_empty, q_pop, f_push;
  logic            accept;
  afsd_pkg::item_t f_item, q_head;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && !q_full;

  afsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wr_en),
    .mode    (mode),
    .accept  (accept),
    .byte_in (bytes.byte_in),
    .last    (bytes.end_of_string),
    .push    (f_push),
    .item    (f_item)
  );

  // Decouples the parser from result-side stalls.
  afsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back end: limit checks and the output register.
  afsd_back #(
    .FLAG_BITS (FLAG_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .limit   (limit),
    .q_valid (q_not_empty),
    .q_item  (q_head),
    .pop     (q_pop),
    .flags   (flags)
  );

endmodule

FILE: bench/flag_decode_checker.sv
// ----------------------------------------------------------------------------
// flag_decode_checker
// Watches the byte and result channels of the flag string decoder. It keeps
// its own copy of the mode, the limit and the per-string parse state, predicts
// the flag beats that the accepted bytes produce, and compares the results
// field by field in order.
// ----------------------------------------------------------------------------
module flag_decode_checker
  import afsd_pkg::*;
#(
  parameter int unsigned FLAG_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  afsd_in_if                   bytes,
  afsd_out_if                  flags,
  output int unsigned          errors,
  output int unsigned          outstanding,
  output int unsigned          flags_seen,
  output logic [7:0]           status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] id;
    logic        valid;
    status_t     status;
    logic        done;
  } flag_beat_t;

  localparam logic [16:0] ID_SPACE = 17'd1 << FLAG_BITS;

  mode_t        mode;
  logic [15:0]  limit;
  logic [7:0]   high_byte;
  logic         have_high;
  logic [16:0]  acc;
  phase_t       phase;
  logic [15:0]  partial;
  logic [1:0]   left;

  flag_beat_t   expected_flags[$];
  int unsigned  fail_count = 0;
  int unsigned  beat_count = 0;
  logic [7:0]   codes_seen = '0;

  assign errors      = fail_count;
  assign flags_seen  = beat_count;
  assign status_seen = codes_seen;

  function automatic void clear_parse();
    high_byte = '0;
    have_high = 1'b0;
    acc       = '0;
    phase     = NP_LEAD;
    partial   = '0;
    left      = '0;
  endfunction

  function automatic logic [16:0] eff_limit();
    return ({1'b0, limit} < ID_SPACE) ? {1'b0, limit} : ID_SPACE;
  endfunction

  // single-byte and UTF-8 ids: only the id space is checked
  function automatic flag_beat_t plain_beat(logic [16:0] id, status_t st, logic done);
    flag_beat_t r;
    if (id >= ID_SPACE) begin
      id = '0;
      st = ST_RANGE;
    end
    r.id     = id[15:0];
    r.valid  = 1'b1;
    r.status = st;
    r.done   = done;
    return r;
  endfunction

  function automatic flag_beat_t number_beat(logic done);
    flag_beat_t r;
    r.id     = acc[15:0];
    r.valid  = 1'b1;
    r.status = ST_OK;
    r.done   = done;
    if (((phase == NP_NEG || phase == NP_STOP_NEG) && acc != '0) || acc >= eff_limit()) begin
      r.id     = '0;
      r.status = ST_RANGE;
    end else if (acc == '0) begin
      r.status = ST_ZERO;
    end
    return r;
  endfunction

  // Advances the parse state by one byte; returns 1 when a flag beat results.
  function automatic bit decode_byte(logic [7:0] b, logic last, output flag_beat_t r);
    bit          hit;
    logic [16:0] wide;
    logic [19:0] grown;
    logic        is_digit;
    hit      = 1'b0;
    r        = '0;
    is_digit = (b >= CH_ZERO && b <= CH_NINE);
    case (mode)
      MODE_PAIR: begin
        if (have_high) begin
          wide     = {1'b0, high_byte, b};
          r.id     = wide[15:0];
          r.valid  = 1'b1;
          r.status = ST_OK;
          r.done   = last;
          if (wide >= eff_limit()) begin
            r.id     = '0;
            r.status = ST_RANGE;
          end
          have_high = 1'b0;
          hit       = 1'b1;
        end else if (last) begin
          r.id     = '0;
          r.valid  = 1'b0;
          r.status = ST_ODD;
          r.done   = 1'b1;
          hit      = 1'b1;
        end else begin
          high_byte = b;
          have_high = 1'b1;
        end
      end
      MODE_DEC: begin
        if (b == CH_COMMA) begin
          r     = number_beat(last);
          acc   = '0;
          phase = NP_LEAD;
          hit   = 1'b1;
        end else begin
          case (phase)
            NP_LEAD: begin
              if (b == CH_PLUS) begin
                phase = NP_POS;
              end else if (b == CH_MINUS) begin
                phase = NP_NEG;
              end else if (is_digit) begin
                phase = NP_POS;
                acc   = 17'(b - CH_ZERO);
              end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                phase = NP_STOP_POS;
              end
            end
            NP_POS, NP_NEG: begin
              if (is_digit) begin
                grown = 20'(acc) * 20'd10 + 20'(b - CH_ZERO);
                acc   = (grown > 20'(ACC_CAP)) ? ACC_CAP : grown[16:0];
              end else begin
                phase = (phase == NP_POS) ? NP_STOP_POS : NP_STOP_NEG;
              end
            end
            default: begin
            end
          endcase
          if (last) begin
            r   = number_beat(1'b1);
            hit = 1'b1;
          end
        end
      end
      MODE_UTF8: begin
        if (left != 2'd0) begin
          if (b[7:6] == 2'b10) begin
            partial = {partial[9:0], b[5:0]};
            left    = left - 2'd1;
            if (left == 2'd0) begin
              r       = plain_beat({1'b0, partial}, ST_OK, last);
              partial = '0;
              hit     = 1'b1;
            end else if (last) begin
              r   = plain_beat({1'b0, REPL_CHAR}, ST_UTF, 1'b1);
              hit = 1'b1;
            end
          end else begin
            left    = '0;
            partial = '0;
            r       = plain_beat({1'b0, REPL_CHAR}, ST_UTF, last);
            hit     = 1'b1;
          end
        end else if (b < 8'h80) begin
          r   = plain_beat({9'd0, b}, ST_OK, last);
          hit = 1'b1;
        end else if (b < 8'hC0 || b >= 8'hF0) begin
          r   = plain_beat({1'b0, REPL_CHAR}, ST_UTF, last);
          hit = 1'b1;
        end else if (last) begin
          r   = plain_beat({1'b0, REPL_CHAR}, ST_UTF, 1'b1);
          hit = 1'b1;
        end else if (b < 8'hE0) begin
          partial = {11'd0, b[4:0]};
          left    = 2'd1;
        end else begin
          partial = {12'd0, b[3:0]};
          left    = 2'd2;
        end
      end
      default: begin
        r   = plain_beat({9'd0, b}, ST_OK, last);
        hit = 1'b1;
      end
    endcase
    if (last) clear_parse();
    return hit;
  endfunction

  always @(posedge clk) begin
    flag_beat_t want;
    flag_beat_t got;
    if (rst) begin
      mode  = MODE_SINGLE;
      limit = LIMIT_RESET;
      clear_parse();
      expected_flags.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MODE) mode = mode_t'(cfg_wr_data[1:0]);
        else limit = cfg_wr_data;
        clear_parse();
      end
      // results first, so a beat can never match a byte taken at the same edge
      if (flags.valid && flags.ready) begin
        got.id     = flags.flag_id;
        got.valid  = flags.flag_valid;
        got.status = status_t'(flags.status);
        got.done   = flags.string_done;
        beat_count++;
        codes_seen[flags.status] = 1'b1;
        if (expected_flags.size() == 0) begin
          $error("unexpected flag beat: flag_id %h status %0d", flags.flag_id, flags.status);
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          if (got.id !== want.id) begin
            $error("flag_id: expected %h, got %h", want.id, got.id);
            fail_count++;
          end
          if (got.valid !== want.valid) begin
            $error("flag_valid: expected %0b, got %0b", want.valid, got.valid);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, flags.status);
            fail_count++;
          end
          if (got.done !== want.done) begin
            $error("string_done: expected %0b, got %0b", want.done, got.done);
            fail_count++;
          end
        end
      end
      if (bytes.valid && bytes.ready) begin
        if (decode_byte(bytes.byte_in, bytes.end_of_string, want))
          expected_flags.push_back(want);
      end
    end
    outstanding <= expected_flags.size();
  end

endmodule

FILE: bench/affix_flag_string_decoder_test.sv
// ----------------------------------------------------------------------------
// affix_flag_string_decoder_test
// Drives flag strings into the decoder in all four modes under several limit
// settings and several idle/stall patterns. A directed opening hits the corner
// cases; random strings follow, mostly well formed with random content. All
// checking is done by flag_decode_checker, which reports its failure count.
// ----------------------------------------------------------------------------
module affix_flag_string_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import afsd_pkg::*;

  typedef logic [7:0] octet_t;

  localparam int LONG_HOLD     = 150;    // receiver hold-off, cycles
  localparam int SETTLE_CYCLES = 4;      // result register sits behind a queue of two
  localparam int PHASES        = 16;     // 4 modes x 4 idle patterns
  localparam int PHASE_BYTES   = 100;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [0:0]          cfg_index;
  logic [LIMIT_W-1:0]  cfg_wr_data;

  afsd_in_if  bytes_if ();
  afsd_out_if flags_if ();

  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned flags_checked;
  logic [7:0]  codes_seen;

  // idle control shared with the receiver process
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_flip;

  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned settings_used;
  octet_t      text_q[$];

  affix_flag_string_decoder #(
    .FLAG_BITS (16)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (bytes_if),
    .flags       (flags_if)
  );

  flag_decode_checker #(
    .FLAG_BITS (16)
  ) decode_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (bytes_if),
    .flags       (flags_if),
    .errors      (fail_count),
    .outstanding (results_pending),
    .flags_seen  (flags_checked),
    .status_seen (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run with an error message if the test hangs.
  initial begin
    #5_000_000;
    $display("affix_flag_string_decoder_test: errors");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off each time hold_flip toggles.
  initial begin : result_sink
    int hold_left;
    bit hold_seen;
    hold_left      = 0;
    hold_seen      = 1'b0;
    flags_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        flags_if.ready <= 1'b0;
      end else begin
        flags_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One beat on the byte channel, with random idle cycles ahead of it.
  // Valid stays high across back-to-back beats.
  task automatic send_byte(input octet_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid         <= 1'b1;
    bytes_if.byte_in       <= b;
    bytes_if.end_of_string <= last;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  // Sender pauses until every predicted result has come back, then lets the
  // pipeline settle (bytes that produce nothing may still be in flight).
  task automatic drain();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller makes sure the block is idle first.
  task automatic write_reg(input cfg_index_t idx, input logic [LIMIT_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void make_raw_text(int max_len);
    text_q.delete();
    repeat ($urandom_range(1, max_len)) text_q.push_back(8'($urandom));
  endfunction

  // Byte pairs; high byte often 0xFF so the limit check is hit. Odd lengths too.
  function automatic void make_pair_text();
    text_q.delete();
    repeat ($urandom_range(1, 8))
      text_q.push_back(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
  endfunction

  // Comma-separated fields: blanks, a sign, digits (sometimes enough to
  // saturate), junk after the number, now and then pure noise or a trailing comma.
  function automatic void make_decimal_text();
    int     fields;
    int     ndig;
    octet_t blanks[6];
    blanks = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    text_q.delete();
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) text_q.push_back(CH_COMMA);
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) text_q.push_back(blanks[$urandom_range(5)]);
        case ($urandom_range(3))
          0: text_q.push_back(CH_PLUS);
          1: text_q.push_back(CH_MINUS);
          default: begin
          end
        endcase
        ndig = ($urandom_range(8) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
        repeat (ndig) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(4) == 0) begin
          text_q.push_back(8'($urandom_range(8'h3A, 8'h7E)));
          if ($urandom_range(1)) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
      end
    end
    if ($urandom_range(5) == 0) text_q.push_back(CH_COMMA);
  endfunction

  // Mostly valid UTF-8 of one to three bytes; some broken sequences and noise,
  // and sometimes a sequence cut off by the end of the string.
  function automatic void make_utf8_text();
    logic [15:0] cp;
    text_q.delete();
    repeat ($urandom_range(1, 5)) begin
      cp = 16'($urandom);
      case ($urandom_range(9))
        0, 1, 2: text_q.push_back({1'b0, cp[6:0]});
        3, 4: begin
          cp = 16'($urandom_range(16'h80, 16'h7FF));
          text_q.push_back({3'b110, cp[10:6]});
          text_q.push_back({2'b10, cp[5:0]});
        end
        5, 6, 7: begin
          cp = 16'($urandom_range(16'h800, 16'hFFFF));
          text_q.push_back({4'b1110, cp[15:12]});
          text_q.push_back({2'b10, cp[11:6]});
          text_q.push_back({2'b10, cp[5:0]});
        end
        8: begin
          // lead byte, maybe one continuation, then a byte that is not a continuation
          text_q.push_back(8'($urandom_range(8'hC0, 8'hEF)));
          if ($urandom_range(1)) text_q.push_back({2'b10, cp[5:0]});
          text_q.push_back($urandom_range(1) ? {1'b0, cp[14:8]} : {2'b11, cp[13:8]});
        end
        default: text_q.push_back(8'($urandom));
      endcase
    end
    if ($urandom_range(6) == 0) begin
      text_q.push_back(8'($urandom_range(8'hC0, 8'hEF)));
      if ($urandom_range(1)) text_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Phase idx: mode = idx % 4, idle pattern = idx / 4; limit cycles through
  // both extremes, the reset value and random values.
  task automatic run_phase(input int idx);
    mode_t               m;
    logic [LIMIT_W-1:0]  lim;
    int unsigned         start;
    m = mode_t'(idx % 4);
    case (idx % 5)
      0:       lim = 16'd1;
      1:       lim = 16'hFFFF;
      2:       lim = LIMIT_RESET;
      default: lim = 16'($urandom_range(1, 65535));
    endcase
    drain();
    case ((idx / 4) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 6; stall_pct = 6; end
    endcase
    write_reg(CFG_MODE, {14'd0, m});
    write_reg(CFG_LIMIT, lim);
    settings_used++;
    // single-byte mode with no idling: hold the result side off so the item
    // queue fills and the byte channel backs up
    if (idx == 0) hold_flip <= ~hold_flip;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      case (m)
        MODE_SINGLE: make_raw_text(6);
        MODE_PAIR:   make_pair_text();
        MODE_DEC:    make_decimal_text();
        default:     make_utf8_text();
      endcase
      send_text();
    end
  endtask

  initial begin : stimulus
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_index              = CFG_MODE;
    cfg_wr_data            = '0;
    bytes_if.valid         = 1'b0;
    bytes_if.byte_in       = '0;
    bytes_if.end_of_string = 1'b0;
    send_idle_pct          = 0;
    stall_pct              = 0;
    hold_flip              = 1'b0;
    bytes_sent             = 0;
    strings_sent           = 0;
    settings_used          = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset mode is single byte: both byte extremes
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();

    // pair mode; a mode write must drop the half-received pair
    drain();
    write_reg(CFG_MODE, {14'd0, MODE_PAIR});
    send_byte(8'hAB, 1'b0);
    drain();
    write_reg(CFG_MODE, {14'd0, MODE_PAIR});
    settings_used++;
    text_q = '{8'h12, 8'h34};            // plain id
    send_text();
    text_q = '{8'hFF, 8'hFF};            // above the reset limit
    send_text();
    text_q = '{8'h41};                   // lone trailing byte
    send_text();

    // decimal: tab skipped, negative, zero, saturating value, trailing comma
    drain();
    write_reg(CFG_MODE, {14'd0, MODE_DEC});
    settings_used++;
    text_q = '{CH_TAB, CH_MINUS, 8'h35, CH_COMMA, CH_ZERO, CH_COMMA,
               CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_COMMA};
    send_text();

    // UTF-8: three-byte char, stray continuation, four-byte lead, lead not
    // followed by a continuation, lead cut off by the end of the string
    drain();
    write_reg(CFG_MODE, {14'd0, MODE_UTF8});
    settings_used++;
    text_q = '{8'hE2, 8'h82, 8'hAC, 8'h80, 8'hF0, 8'hC3, 8'h41, 8'hE2};
    send_text();

    // --- random ---
    for (int p = 0; p < PHASES; p++) run_phase(p);

    drain();
    $display("%0d bytes in %0d strings under %0d register settings, %0d flag beats checked",
             bytes_sent, strings_sent, settings_used, flags_checked);
    $display("status codes returned (one bit per code): %b", codes_seen);
    if (fail_count == 0 && results_pending == 0) begin
      $display("affix_flag_string_decoder_test: clean");
    end else begin
      $display("affix_flag_string_decoder_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/afsd_pkg.sv
hw/rtl/afsd_in_if.sv
hw/rtl/afsd_out_if.sv
hw/rtl/afsd_front.sv
hw/rtl/afsd_queue.sv
hw/rtl/afsd_back.sv
hw/rtl/affix_flag_string_decoder.sv
bench/flag_decode_checker.sv
bench/affix_flag_string_decoder_test.sv
